@@ hw/rtl/tiw_pkg.sv @@
package tiw_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned XW         = 32;
  localparam int unsigned IDX_W      = 9;
  localparam int unsigned OUT_IDX_W  = 8;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned QIDX_W     = 9;
  localparam int unsigned DIFF_W     = XW + 1;
  localparam int unsigned MAX_PTS    = 4;
  localparam int unsigned NFACT      = MAX_PTS - 1;
  localparam int unsigned SCHEME_W   = 3;
  localparam int unsigned POINTS_W   = 9;
  localparam int unsigned M_W        = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic signed [XW-1:0] ONE_Q24 = 32'sh0100_0000;
  localparam logic signed [XW-1:0] W_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [XW-1:0] W_MIN   = 32'sh8000_0000;

  localparam logic [POINTS_W-1:0] POINTS_RESET = 9'd2;

  typedef enum logic [SCHEME_W-1:0] {
    SCHEME_FLOOR,
    SCHEME_CEIL,
    SCHEME_LINEAR,
    SCHEME_QUADRATIC,
    SCHEME_CUBIC
  } scheme_e;

  typedef enum logic {
    MODE_LOAD,
    MODE_QUERY
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCHEME,
    REG_POINTS
  } reg_e;

  typedef struct packed {
    logic [XW-1:0]                 x;
    logic [MAX_PTS-1:0][XW-1:0]    pts;
    logic [IDX_W-1:0]              lo;
    logic [IDX_W-1:0]              nm1;
    logic [M_W-1:0]                m;
    logic                          unit;
    logic                          step;
  } stencil_t;

  typedef struct packed {
    logic [NFACT-1:0][DIFF_W-1:0]  nd;
    logic [NFACT-1:0][DIFF_W-1:0]  dd;
    logic [OUT_IDX_W-1:0]          idx;
    logic                          unit;
    logic                          comp;
    logic                          last;
  } witem_t;

endpackage

@@ hw/rtl/tiw_intf.sv @@
interface tiw_in_if;
  import tiw_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [SLOT_W-1:0]        load_slot;
  logic signed [XW-1:0]     load_value;
  logic signed [XW-1:0]     query_x;
  logic signed [QIDX_W-1:0] query_index;
  modport source (output valid, mode, load_slot, load_value, query_x, query_index,
                  input ready);
  modport sink (input valid, mode, load_slot, load_value, query_x, query_index,
                output ready);
endinterface

interface tiw_out_if;
  import tiw_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OUT_IDX_W-1:0]    table_index;
  logic signed [XW-1:0]    weight;
  logic                    last;
  logic                    divide_fault;
  modport source (output valid, table_index, weight, last, divide_fault, input ready);
  modport sink (input valid, table_index, weight, last, divide_fault, output ready);
endinterface

interface tiw_cfg_if;
  import tiw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/tiw_fetch.sv @@
module tiw_fetch #(
  parameter int unsigned TABLE_DEPTH = tiw_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = tiw_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tiw_in_if.sink                          in_i,
  input  logic [tiw_pkg::SCHEME_W-1:0]    scheme_i,
  input  logic [tiw_pkg::POINTS_W-1:0]    points_i,
  input  logic                            st_take_i,
  output tiw_pkg::stencil_t               st_o,
  output logic                            st_valid_o
);
  import tiw_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned VW = (VALUE_WIDTH < XW) ? VALUE_WIDTH : XW;

  logic [VW-1:0] bp_mem [TABLE_DEPTH];

  stencil_t          q_q, gm_q, st_q, q_d, st_d;
  logic              q_valid_q, st_valid_q;
  logic [1:0]        r_q, rslot_q;
  logic              rvalid_q, rlast_q;
  logic [VW-1:0]     rd_q;
  logic [MAX_PTS-1:0][XW-1:0] g_q;

  logic              st_free, blocked, issue, last_issue, acc, q_load, complete;
  logic [IDX_W-1:0]  nm1, c_unit, raddr;
  logic [IDX_W:0]    rsum;
  logic signed [10:0] lo0, hi0, lo1, kk, nn;
  logic [M_W-1:0]    m_in;

  assign st_free    = !st_valid_q || st_take_i;
  assign blocked    = rvalid_q && rlast_q && !st_free;
  assign issue      = q_valid_q && !blocked;
  assign last_issue = issue && ({1'b0, r_q} == (q_q.m - M_W'(1)));
  assign in_i.ready = !q_valid_q || last_issue;
  assign acc        = in_i.valid && in_i.ready;
  assign q_load     = acc && (in_i.mode == MODE_QUERY) && (scheme_i <= SCHEME_CUBIC);
  assign complete   = rvalid_q && rlast_q && st_free;

  assign rsum  = {1'b0, q_q.lo} + (IDX_W + 1)'(r_q);
  assign raddr = (rsum > {1'b0, q_q.nm1}) ? q_q.nm1 : rsum[IDX_W-1:0];

  always_comb begin
    if (points_i == '0) begin
      nm1 = '0;
    end else if (32'(points_i) > TABLE_DEPTH) begin
      nm1 = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      nm1 = points_i - POINTS_W'(1);
    end

    if (in_i.query_index < 0) begin
      c_unit = '0;
    end else if ($unsigned(in_i.query_index) > nm1) begin
      c_unit = nm1;
    end else begin
      c_unit = $unsigned(in_i.query_index);
    end

    kk  = $signed(11'(scheme_i)) - 11'sd1;
    nn  = $signed(11'(nm1));
    lo0 = 11'(in_i.query_index);
    if (scheme_i == SCHEME_QUADRATIC || scheme_i == SCHEME_CUBIC) begin
      lo0 = lo0 - 11'sd1;
    end
    if (lo0 < 11'sd0) begin
      lo0 = 11'sd0;
    end
    hi0 = lo0 + kk;
    if (hi0 > nn) begin
      hi0 = nn;
    end
    lo1 = hi0 - kk;
    if (lo1 < 11'sd0) begin
      lo1 = 11'sd0;
    end

    m_in = (scheme_i <= SCHEME_CEIL) ? M_W'(1) : scheme_i;

    q_d      = '0;
    q_d.x    = 32'($signed(in_i.query_x[VW-1:0]));
    q_d.nm1  = nm1;
    q_d.m    = m_in;
    q_d.unit = (scheme_i <= SCHEME_CEIL);
    q_d.step = (scheme_i == SCHEME_CEIL) && !(in_i.query_index < 0);
    q_d.lo   = q_d.unit ? c_unit : lo1[IDX_W-1:0];
  end

  always_comb begin
    st_d = gm_q;
    for (int s = 0; s < MAX_PTS; s++) begin
      st_d.pts[s] = (rslot_q == 2'(s)) ? 32'($signed(rd_q)) : g_q[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && in_i.mode == MODE_LOAD && 32'(in_i.load_slot) < TABLE_DEPTH) begin
      bp_mem[AW'(in_i.load_slot)] <= in_i.load_value[VW-1:0];
    end
    if (issue) begin
      rd_q <= bp_mem[AW'(raddr)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_load) begin
      q_q <= q_d;
    end
    if (last_issue) begin
      gm_q <= q_q;
    end
    if (issue) begin
      rslot_q <= r_q;
      rlast_q <= last_issue;
    end
    if (rvalid_q && !rlast_q) begin
      g_q[rslot_q] <= 32'($signed(rd_q));
    end
    if (complete) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_valid_q  <= 1'b0;
      r_q        <= '0;
      rvalid_q   <= 1'b0;
      st_valid_q <= 1'b0;
    end else begin
      if (q_load) begin
        q_valid_q <= 1'b1;
      end else if (last_issue) begin
        q_valid_q <= 1'b0;
      end
      if (q_load || last_issue) begin
        r_q <= '0;
      end else if (issue) begin
        r_q <= r_q + 2'd1;
      end
      rvalid_q <= issue || blocked;
      if (complete) begin
        st_valid_q <= 1'b1;
      end else if (st_take_i) begin
        st_valid_q <= 1'b0;
      end
    end
  end

  assign st_o       = st_q;
  assign st_valid_o = st_valid_q;

  a_st_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_valid_q && !st_take_i |=> st_valid_q && $stable(st_q.lo))
    else $error("stencil dropped while waiting");

  a_pend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blocked |=> rvalid_q && rlast_q && $stable(rslot_q))
    else $error("pending last read lost");

endmodule

@@ hw/rtl/tiw_seq.sv @@
module tiw_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tiw_pkg::stencil_t   st_i,
  input  logic                st_valid_i,
  input  logic                en_i,
  output logic                st_take_o,
  output tiw_pkg::witem_t     wi_o,
  output logic                wi_valid_o
);
  import tiw_pkg::*;

  logic [1:0]        j_q, jj;
  logic              issue, lastj;
  witem_t            wi_q, wi_d;
  logic [XW-1:0]     pj, pick;
  logic [IDX_W:0]    psum;
  logic [IDX_W-1:0]  c;
  logic              in_use;
  logic [2:0]        o;

  assign issue     = st_valid_i && en_i;
  assign lastj     = ({1'b0, j_q} == (st_i.m - M_W'(1)));
  assign st_take_o = issue && lastj;

  always_comb begin
    jj = (st_i.m == M_W'(2)) ? 2'd1 : j_q;
    case (jj)
      2'd0:    pj = st_i.pts[0];
      2'd1:    pj = st_i.pts[1];
      2'd2:    pj = st_i.pts[2];
      default: pj = st_i.pts[3];
    endcase

    wi_d      = '0;
    wi_d.unit = st_i.unit;
    wi_d.comp = (st_i.m == M_W'(2)) && (j_q == 2'd0);
    wi_d.last = lastj;

    for (int i = 0; i < NFACT; i++) begin
      if (2'(i) < jj) begin
        o    = 3'(i);
        pick = st_i.pts[i];
      end else begin
        o    = 3'(i + 1);
        pick = st_i.pts[i + 1];
      end
      in_use = o < st_i.m;
      if (in_use) begin
        wi_d.nd[i] = {st_i.x[XW-1], st_i.x} - {pick[XW-1], pick};
        wi_d.dd[i] = {pj[XW-1], pj} - {pick[XW-1], pick};
      end else begin
        wi_d.nd[i] = DIFF_W'(1);
        wi_d.dd[i] = DIFF_W'(1);
      end
    end

    psum = {1'b0, st_i.lo} + (IDX_W + 1)'(j_q);
    if (st_i.unit) begin
      c = st_i.lo;
      if (st_i.step && st_i.x != st_i.pts[0] && st_i.lo < st_i.nm1) begin
        c = st_i.lo + IDX_W'(1);
      end
    end else if (psum > {1'b0, st_i.nm1}) begin
      c = st_i.nm1;
    end else begin
      c = psum[IDX_W-1:0];
    end
    wi_d.idx = c[OUT_IDX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i && issue) begin
      wi_q <= wi_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q        <= '0;
      wi_valid_o <= 1'b0;
    end else if (en_i) begin
      wi_valid_o <= issue;
      if (issue) begin
        j_q <= lastj ? 2'd0 : j_q + 2'd1;
      end
    end
  end

  assign wi_o = wi_q;

endmodule

@@ hw/rtl/tiw_wpipe.sv @@
module tiw_wpipe (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tiw_pkg::witem_t   wi_i,
  input  logic              wi_valid_i,
  output logic              en_o,
  tiw_out_if.source         out_o
);
  import tiw_pkg::*;

  localparam int unsigned PW   = 2 * DIFF_W;
  localparam int unsigned NUMW = 3 * DIFF_W;
  localparam int unsigned AXW  = NUMW + 26;
  localparam int unsigned D2W  = NUMW + 1;
  localparam int unsigned QW   = DIFF_W;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] idx;
    logic                 unit;
    logic                 comp;
    logic                 last;
  } meta_t;

  typedef struct packed {
    logic [NFACT-1:0][DIFF_W-1:0] nm;
    logic [NFACT-1:0][DIFF_W-1:0] dm;
    logic                         nneg;
    logic                         dneg;
    meta_t                        md;
  } s2_t;

  typedef struct packed {
    logic [PW-1:0]     n01;
    logic [PW-1:0]     d01;
    logic [DIFF_W-1:0] n2;
    logic [DIFF_W-1:0] d2;
    logic              nneg;
    logic              dneg;
    meta_t             md;
  } s3_t;

  typedef struct packed {
    logic [PW-1:0] nlo;
    logic [PW-1:0] nhi;
    logic [PW-1:0] dlo;
    logic [PW-1:0] dhi;
    logic          nneg;
    logic          dneg;
    meta_t         md;
  } s4_t;

  typedef struct packed {
    logic [NUMW-1:0] num;
    logic [NUMW-1:0] den;
    logic            nneg;
    logic            dneg;
    meta_t           md;
  } s5_t;

  typedef struct packed {
    logic [AXW-1:0] a;
    logic [D2W-1:0] d2;
    logic           dz;
    logic           nnz;
    logic           nneg;
    logic           dneg;
    meta_t          md;
  } s6_t;

  typedef struct packed {
    logic [D2W-1:0] rem;
    logic [QW-1:0]  alow;
    logic [D2W-1:0] d2;
    logic [QW-1:0]  q;
    logic           ovf;
    logic           dz;
    logic           nnz;
    logic           nneg;
    logic           dneg;
    meta_t          md;
  } dv_t;

  typedef struct packed {
    logic [XW-1:0] w;
    logic          fault;
    meta_t         md;
  } f_t;

  function automatic dv_t div_step(dv_t s);
    dv_t          r;
    logic [D2W:0] sh;
    logic         ge;
    r  = s;
    sh = {s.rem, s.alow[QW-1]};
    ge = sh >= {1'b0, s.d2};
    if (ge) begin
      sh = sh - {1'b0, s.d2};
    end
    r.rem  = sh[D2W-1:0];
    r.alow = {s.alow[QW-2:0], 1'b0};
    r.q    = {s.q[QW-2:0], ge};
    return r;
  endfunction

  logic              en;
  s2_t               s2_q, s2_d;
  s3_t               s3_q, s3_d;
  s4_t               s4_q, s4_d;
  s5_t               s5_q, s5_d;
  s6_t               s6_q, s6_d;
  dv_t               dv_q [QW+1];
  dv_t               dv_d [QW+1];
  f_t                f_q, f_d;
  logic              s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, f_v_q, o_v_q;
  logic [QW:0]       dv_v_q;
  logic [OUT_IDX_W-1:0] o_idx_q;
  logic [XW-1:0]     o_w_q, o_w_d;
  logic              o_last_q, o_fault_q;
  logic              neg;
  logic [QW-1:0]     lim;
  logic signed [XW+1:0] t;

  assign en   = !o_v_q || out_o.ready;
  assign en_o = en;

  always_comb begin
    s2_d      = '0;
    s2_d.md   = '{idx: wi_i.idx, unit: wi_i.unit, comp: wi_i.comp, last: wi_i.last};
    for (int i = 0; i < NFACT; i++) begin
      s2_d.nm[i] = wi_i.nd[i][DIFF_W-1] ? DIFF_W'(-wi_i.nd[i]) : wi_i.nd[i];
      s2_d.dm[i] = wi_i.dd[i][DIFF_W-1] ? DIFF_W'(-wi_i.dd[i]) : wi_i.dd[i];
      s2_d.nneg  = s2_d.nneg ^ wi_i.nd[i][DIFF_W-1];
      s2_d.dneg  = s2_d.dneg ^ wi_i.dd[i][DIFF_W-1];
    end

    s3_d.n01  = PW'(s2_q.nm[0]) * PW'(s2_q.nm[1]);
    s3_d.d01  = PW'(s2_q.dm[0]) * PW'(s2_q.dm[1]);
    s3_d.n2   = s2_q.nm[2];
    s3_d.d2   = s2_q.dm[2];
    s3_d.nneg = s2_q.nneg;
    s3_d.dneg = s2_q.dneg;
    s3_d.md   = s2_q.md;

    s4_d.nlo  = PW'(s3_q.n01[DIFF_W-1:0]) * PW'(s3_q.n2);
    s4_d.nhi  = PW'(s3_q.n01[PW-1:DIFF_W]) * PW'(s3_q.n2);
    s4_d.dlo  = PW'(s3_q.d01[DIFF_W-1:0]) * PW'(s3_q.d2);
    s4_d.dhi  = PW'(s3_q.d01[PW-1:DIFF_W]) * PW'(s3_q.d2);
    s4_d.nneg = s3_q.nneg;
    s4_d.dneg = s3_q.dneg;
    s4_d.md   = s3_q.md;

    s5_d.num  = NUMW'(s4_q.nlo) + {s4_q.nhi, {DIFF_W{1'b0}}};
    s5_d.den  = NUMW'(s4_q.dlo) + {s4_q.dhi, {DIFF_W{1'b0}}};
    s5_d.nneg = s4_q.nneg;
    s5_d.dneg = s4_q.dneg;
    s5_d.md   = s4_q.md;

    s6_d.a    = {1'b0, s5_q.num, 25'b0} + AXW'(s5_q.den);
    s6_d.d2   = {s5_q.den, 1'b0};
    s6_d.dz   = (s5_q.den == '0);
    s6_d.nnz  = (s5_q.num != '0);
    s6_d.nneg = s5_q.nneg;
    s6_d.dneg = s5_q.dneg;
    s6_d.md   = s5_q.md;

    dv_d[0].ovf  = (D2W'(s6_q.a[AXW-1:QW]) >= s6_q.d2);
    dv_d[0].rem  = D2W'(s6_q.a[AXW-1:QW]);
    dv_d[0].alow = s6_q.a[QW-1:0];
    dv_d[0].d2   = s6_q.d2;
    dv_d[0].q    = '0;
    dv_d[0].dz   = s6_q.dz;
    dv_d[0].nnz  = s6_q.nnz;
    dv_d[0].nneg = s6_q.nneg;
    dv_d[0].dneg = s6_q.dneg;
    dv_d[0].md   = s6_q.md;
    for (int i = 1; i <= QW; i++) begin
      dv_d[i] = div_step(dv_q[i-1]);
    end

    neg      = dv_q[QW].nneg ^ dv_q[QW].dneg;
    lim      = neg ? QW'(33'h0_8000_0000) : QW'(33'h0_7FFF_FFFF);
    f_d.md   = dv_q[QW].md;
    f_d.fault = dv_q[QW].dz;
    if (dv_q[QW].dz) begin
      f_d.w = (dv_q[QW].nneg && dv_q[QW].nnz) ? W_MIN : W_MAX;
    end else if (dv_q[QW].ovf || dv_q[QW].q > lim) begin
      f_d.w = neg ? W_MIN : W_MAX;
    end else begin
      f_d.w = neg ? XW'(-dv_q[QW].q) : XW'(dv_q[QW].q);
    end

    t = (XW + 2)'(ONE_Q24) - (XW + 2)'($signed(f_q.w));
    if (f_q.md.unit) begin
      o_w_d = ONE_Q24;
    end else if (f_q.md.comp) begin
      if (t > (XW + 2)'(W_MAX)) begin
        o_w_d = W_MAX;
      end else if (t < (XW + 2)'(W_MIN)) begin
        o_w_d = W_MIN;
      end else begin
        o_w_d = t[XW-1:0];
      end
    end else begin
      o_w_d = f_q.w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      s5_q <= s5_d;
      s6_q <= s6_d;
      for (int i = 0; i <= QW; i++) begin
        dv_q[i] <= dv_d[i];
      end
      f_q       <= f_d;
      o_idx_q   <= f_q.md.idx;
      o_w_q     <= o_w_d;
      o_last_q  <= f_q.md.last;
      o_fault_q <= f_q.fault && !f_q.md.unit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      dv_v_q <= '0;
      f_v_q  <= 1'b0;
      o_v_q  <= 1'b0;
    end else if (en) begin
      s2_v_q <= wi_valid_i;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
      dv_v_q <= {dv_v_q[QW-1:0], s6_v_q};
      f_v_q  <= dv_v_q[QW];
      o_v_q  <= f_v_q;
    end
  end

  assign out_o.valid        = o_v_q;
  assign out_o.table_index  = o_idx_q;
  assign out_o.weight       = o_w_q;
  assign out_o.last         = o_last_q;
  assign out_o.divide_fault = o_fault_q;

  a_fault_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_v_q && f_q.fault |-> (f_q.w == W_MAX || f_q.w == W_MIN))
    else $error("faulted weight not saturated");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dv_v_q) && $stable(f_v_q) && $stable(s2_v_q))
    else $error("pipeline moved during stall");

endmodule

@@ hw/rtl/table_interpolation_weights_unit.sv @@
// Lagrange interpolation weights over a table of up to TABLE_DEPTH ascending Q16.16
// breakpoints. A load item writes one breakpoint; a query item returns one result item per
// stencil point (1 for floor/ceil, 2 linear, 3 quadratic, 4 cubic), the last one flagged.
// The table is a single-port-read memory, so a query occupies the fetch stage until all of
// its stencil points are read; the result channel issues one weight per cycle while the
// output is ready and stencils are available. Loads are taken one per cycle while no query
// occupies the fetch stage. Results pass through the weight pipeline (multiply stages and
// a one-bit-per-stage divider of 33 stages). A load waits until the stencil reads of the
// query ahead of it have been issued. Breakpoints are not cleared at reset.
module table_interpolation_weights_unit #(
  parameter int unsigned TABLE_DEPTH = tiw_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = tiw_pkg::VALUE_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tiw_cfg_if.sink    cfg_i,
  tiw_in_if.sink     in_i,
  tiw_out_if.source  out_o
);
  import tiw_pkg::*;

  logic [SCHEME_W-1:0] scheme_q;
  logic [POINTS_W-1:0] points_q;
  stencil_t            st;
  logic                st_valid, st_take, wi_valid, en;
  witem_t              wi;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scheme_q <= SCHEME_LINEAR;
      points_q <= POINTS_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_SCHEME) begin
        scheme_q <= cfg_i.data[SCHEME_W-1:0];
      end else if (cfg_i.index == REG_POINTS) begin
        points_q <= cfg_i.data[POINTS_W-1:0];
      end
    end
  end

  tiw_fetch #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_fetch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .scheme_i   (scheme_q),
    .points_i   (points_q),
    .st_take_i  (st_take),
    .st_o       (st),
    .st_valid_o (st_valid)
  );

  tiw_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .st_i       (st),
    .st_valid_i (st_valid),
    .en_i       (en),
    .st_take_o  (st_take),
    .wi_o       (wi),
    .wi_valid_o (wi_valid)
  );

  tiw_wpipe u_wpipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wi_i       (wi),
    .wi_valid_i (wi_valid),
    .en_o       (en),
    .out_o      (out_o)
  );

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  import tiw_pkg::*;

  localparam int FILL_N = 16;

  typedef struct {
    mode_e                    mode;
    logic [SLOT_W-1:0]        slot;
    logic signed [XW-1:0]     value;
    logic signed [XW-1:0]     x;
    logic signed [QIDX_W-1:0] qi;
  } req_t;

  typedef struct {
    logic [OUT_IDX_W-1:0] idx;
    logic signed [XW-1:0] weight;
    logic                 last;
    logic                 fault;
  } wres_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tiw_in_if  in_ch ();
  tiw_out_if out_ch ();
  tiw_cfg_if cfg_ch ();

  table_interpolation_weights_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch.sink),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  req_t  pending_q[$];
  wres_t weights_due[$];
  logic signed [XW-1:0] bp_model[TABLE_DEPTH_DEF];
  logic signed [XW-1:0] bp_shadow[TABLE_DEPTH_DEF];
  logic [SCHEME_W-1:0]  scheme_now = SCHEME_LINEAR;
  logic [POINTS_W-1:0]  points_now = POINTS_RESET;
  int  gen_n;
  int  hi_b;
  bit  calm;
  bit  failed;
  int  quiet_cycles;

  function automatic longint sat_w(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic longint lagrange_w(int j, int m, longint x, longint p[4], output bit flt);
    logic [127:0] num, den, q, lim;
    logic [63:0]  ud;
    bit nneg, dneg, neg;
    longint d;
    num = 1;
    den = 1;
    nneg = 0;
    dneg = 0;
    for (int k = 0; k < m; k++) begin
      if (k != j) begin
        d = x - p[k];
        if (d < 0) begin
          nneg ^= 1;
          d = -d;
        end
        ud = d;
        num = num * {64'd0, ud};
        d = p[j] - p[k];
        if (d < 0) begin
          dneg ^= 1;
          d = -d;
        end
        ud = d;
        den = den * {64'd0, ud};
      end
    end
    if (den == 0) begin
      flt = 1;
      return (nneg && num != 0) ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
    end
    flt = 0;
    q = ((num << 25) + den) / (den << 1);
    neg = nneg ^ dneg;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) q = lim;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic void predict_weights(req_t r);
    longint n, x, qi, c, lo, hi, pnt;
    longint pts[4], w[4];
    int idx[4];
    bit flt[4];
    int m, k;
    wres_t e;
    if (r.mode == MODE_LOAD) begin
      bp_model[r.slot] = r.value;
      return;
    end
    n = points_now;
    if (n < 1) n = 1;
    if (n > TABLE_DEPTH_DEF) n = TABLE_DEPTH_DEF;
    x = r.x;
    qi = r.qi;
    if (scheme_now == SCHEME_FLOOR || scheme_now == SCHEME_CEIL) begin
      if (scheme_now == SCHEME_FLOOR) begin
        c = qi < 0 ? 0 : (qi > n - 1 ? n - 1 : qi);
      end else if (qi < 0) begin
        c = 0;
      end else begin
        c = qi > n - 1 ? n - 1 : qi;
        if (x != longint'(bp_model[c])) c++;
        if (c > n - 1) c = n - 1;
      end
      idx[0] = int'(c);
      w[0] = 64'sh0100_0000;
      flt[0] = 0;
      m = 1;
    end else if (scheme_now <= SCHEME_CUBIC) begin
      k = int'(scheme_now) - 1;
      m = k + 1;
      lo = qi - (k > 1 ? 1 : 0);
      if (lo < 0) lo = 0;
      hi = lo + k;
      if (hi > n - 1) hi = n - 1;
      lo = hi - k;
      if (lo < 0) lo = 0;
      for (int j = 0; j < m; j++) begin
        pnt = lo + j;
        if (pnt > n - 1) pnt = n - 1;
        idx[j] = int'(pnt);
        pts[j] = bp_model[pnt];
      end
      if (m == 2) begin
        w[1] = lagrange_w(1, 2, x, pts, flt[1]);
        w[0] = sat_w(64'sh0100_0000 - w[1]);
        flt[0] = flt[1];
      end else begin
        for (int j = 0; j < m; j++) w[j] = lagrange_w(j, m, x, pts, flt[j]);
      end
    end else begin
      return;
    end
    for (int j = 0; j < m; j++) begin
      e.idx = OUT_IDX_W'(idx[j]);
      e.weight = XW'(w[j]);
      e.last = (j == m - 1);
      e.fault = flt[j];
      weights_due.push_back(e);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    req_t r;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.mode <= MODE_LOAD;
      in_ch.load_slot <= '0;
      in_ch.load_value <= '0;
      in_ch.query_x <= '0;
      in_ch.query_index <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        r.mode = mode_e'(in_ch.mode);
        r.slot = in_ch.load_slot;
        r.value = in_ch.load_value;
        r.x = in_ch.query_x;
        r.qi = in_ch.query_index;
        predict_weights(r);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 9)) begin
          r = pending_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mode <= r.mode;
          in_ch.load_slot <= r.slot;
          in_ch.load_value <= r.value;
          in_ch.query_x <= r.x;
          in_ch.query_index <= r.qi;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    wres_t e;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (weights_due.size() == 0) begin
          $display("%0t: unexpected result idx=%0d weight=%h", $time, out_ch.table_index,
                   out_ch.weight);
          failed = 1;
        end else begin
          e = weights_due.pop_front();
          if (out_ch.table_index !== e.idx) begin
            $display("%0t: table_index expected %0d actual %0d", $time, e.idx,
                     out_ch.table_index);
            failed = 1;
          end
          if (out_ch.weight !== e.weight) begin
            $display("%0t: weight expected %h actual %h", $time, e.weight, out_ch.weight);
            failed = 1;
          end
          if (out_ch.last !== e.last) begin
            $display("%0t: last expected %b actual %b", $time, e.last, out_ch.last);
            failed = 1;
          end
          if (out_ch.divide_fault !== e.fault) begin
            $display("%0t: divide_fault expected %b actual %b", $time, e.fault,
                     out_ch.divide_fault);
            failed = 1;
          end
        end
      end
      out_ch.ready <= calm || $urandom_range(99) >= 9;
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic push_load(int slot, logic signed [XW-1:0] v);
    req_t r;
    r.mode = MODE_LOAD;
    r.slot = SLOT_W'(slot);
    r.value = v;
    r.x = $urandom;
    r.qi = QIDX_W'($urandom);
    if (slot < TABLE_DEPTH_DEF) bp_shadow[slot] = v;
    pending_q.push_back(r);
  endtask

  task automatic push_query(logic signed [XW-1:0] x, logic signed [QIDX_W-1:0] qi);
    req_t r;
    r.mode = MODE_QUERY;
    r.slot = SLOT_W'($urandom);
    r.value = $urandom;
    r.x = x;
    r.qi = qi;
    pending_q.push_back(r);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_ch.valid || weights_due.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic cfg_write(reg_e r, logic [CFG_DATA_W-1:0] d);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data <= d;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (r == REG_SCHEME) scheme_now = d[SCHEME_W-1:0];
    else points_now = d;
  endtask

  task automatic random_items(int count);
    int b, gap;
    logic signed [XW-1:0] x;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: begin
          if ($urandom_range(1)) push_load($urandom_range(hi_b), $urandom);
          else begin
            b = $urandom_range(hi_b);
            push_load(b, bp_shadow[b > 0 ? b - 1 : 0]);
          end
        end
        1: begin
          b = $urandom_range(511);
          if (b < 256 && b > hi_b && gen_n > FILL_N) b = hi_b;
          push_query($urandom, QIDX_W'(b));
        end
        2: push_query(bp_shadow[0] - $urandom_range(200000), -1);
        default: begin
          b = $urandom_range(hi_b);
          gap = (b + 1 < gen_n && bp_shadow[b + 1] > bp_shadow[b]) ?
                bp_shadow[b + 1] - bp_shadow[b] : 65536;
          if (gap > 1000000) gap = 1000000;
          x = bp_shadow[b] + $urandom_range(gap);
          push_query(x, QIDX_W'(b));
        end
      endcase
    end
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] sch, logic [CFG_DATA_W-1:0] pts, int count);
    drain();
    cfg_write(REG_SCHEME, sch);
    cfg_write(REG_POINTS, pts);
    gen_n = pts == 0 ? 1 : (pts > TABLE_DEPTH_DEF ? TABLE_DEPTH_DEF : pts);
    hi_b = gen_n <= FILL_N ? gen_n - 1 : FILL_N - 3;
    push_query(32'sh8000_0000, -1);
    push_query(32'sh7FFF_FFFF, 255);
    push_query(bp_shadow[gen_n - 1], QIDX_W'(gen_n - 1));
    random_items(count);
  endtask

  initial begin
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_SCHEME;
    cfg_ch.data <= '0;
    calm = 0;
    failed = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < FILL_N; i++) push_load(i, (i - 128) * 65536 + $urandom_range(30000));
    for (int i = TABLE_DEPTH_DEF - 4; i < TABLE_DEPTH_DEF; i++) begin
      push_load(i, (i - 128) * 65536 + $urandom_range(30000));
    end
    push_load(3, 32'sh8000_0000);
    push_load(4, 32'sh7FFF_FFFF);
    push_load(3, -131072 * 128 + 5);
    push_load(4, -131072 * 62);
    gen_n = 2;
    hi_b = 1;
    random_items(4);
    run_phase(SCHEME_FLOOR, 256, 6);
    run_phase(SCHEME_CEIL, 1, 4);
    run_phase(SCHEME_CEIL, 12, 6);
    calm = 1;
    run_phase(SCHEME_LINEAR, 3, 10);
    run_phase(SCHEME_QUADRATIC, 4, 10);
    calm = 0;
    run_phase(SCHEME_CUBIC, 256, 8);
    run_phase(SCHEME_CUBIC, 2, 4);
    run_phase(SCHEME_QUADRATIC, 0, 4);
    run_phase(5, 10, 2);
    run_phase(7, 10, 2);
    run_phase(SCHEME_LINEAR, 511, 6);
    run_phase(SCHEME_CUBIC, 6, 6);
    drain();
    repeat (100) @(posedge clk_i);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
